// ===== rtl/tsb_pkg.sv =====
// ---------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the software timer bank
// command codes, timer status codes, request/result structs, row layout
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsb_pkg;

  localparam int DEFAULT_NUM_TIMERS = 16;
  localparam int MASK_BITS          = 16;
  localparam logic [31:0] TICK_WRAP = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_START      = 3'd1,
    CMD_START_BASE = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_SUSPEND    = 3'd4,
    CMD_RESUME     = 3'd5,
    CMD_RESET      = 3'd6,
    CMD_QUERY      = 3'd7
  } cmd_t;

  localparam logic [1:0] TS_FINISHED  = 2'd0;
  localparam logic [1:0] TS_RUNNING   = 2'd1;
  localparam logic [1:0] TS_SUSPENDED = 2'd2;

  typedef struct packed {
    cmd_t        command;
    logic [3:0]  timer_index;
    logic [31:0] duration_ms;
    logic [31:0] base_time_ms;
    logic        want_remaining;
  } in_t;

  typedef struct packed {
    logic [31:0]          result_ms;
    logic [31:0]          elapsed_ms;
    logic [1:0]           timer_state;
    logic [MASK_BITS-1:0] expired_mask;
    logic [31:0]          now_ms;
  } out_t;

  // per-timer time words kept in the row memory
  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] stop_time;
    logic [31:0] paused_remainder;
  } row_t;

  // operands for the shared adder
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

endpackage

// ===== rtl/tsb_alu.sv =====
// ---------------------------------------------------------------------------
// tsb_alu: shared 32-bit add/subtract unit
// a + b or a - b modulo 2^32, carry out doubles as the a >= b flag on subtract
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsb_alu (
  input  tsb_pkg::alu_req_t req,
  output logic [31:0]       sum,
  output logic              carry
);
  import tsb_pkg::*;

  logic [32:0] full;
  logic [31:0] b_in;

  assign b_in  = req.sub ? ~req.b : req.b;
  assign full  = {1'b0, req.a} + {1'b0, b_in} + {32'd0, req.sub};
  assign sum   = full[31:0];
  assign carry = full[32];

endmodule

// ===== rtl/tsb_row_mem.sv =====
// ---------------------------------------------------------------------------
// tsb_row_mem: single-port row memory for per-timer time words
// registered read, one valid bit per row so unwritten rows read as zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsb_row_mem #(
  parameter int DEPTH = tsb_pkg::DEFAULT_NUM_TIMERS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  tsb_pkg::row_t wdata,
  output tsb_pkg::row_t rdata
);
  import tsb_pkg::*;

  row_t             mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  row_t             rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= row_valid[addr];
      if (we) begin
        row_valid[addr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

// ===== rtl/software_timer_bank_top.sv =====
// ---------------------------------------------------------------------------
// software_timer_bank_top: bank of millisecond timers on one tick count
// sequencer around a shared adder and a single-port row memory
// ---------------------------------------------------------------------------
// Each request carries one command for one timer and gives exactly one
// result. A non-tick command addressed to a timer in the bank steps through
// read row, operate, elapsed time and write back, and deliver; one addressed
// outside the bank goes straight to deliver. On a tick the count advances,
// then every timer is compared against the new count, one timer per cycle
// through the row memory's single port and the shared adder, then the
// addressed timer is reported through the read, operate and write-back steps
// unless its index is outside the bank. in_ready is high only while no
// request is in flight; a finished result sits in the output register, so the
// next request is taken while the previous result still waits. The tick count
// wraps to 0 when it would reach all-ones, and expiry compares stop time to
// the count as plain unsigned numbers. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module software_timer_bank_top #(
  parameter int NUM_TIMERS = tsb_pkg::DEFAULT_NUM_TIMERS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tsb_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output tsb_pkg::out_t out_item
);
  import tsb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TINC = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_READ = 7'b0001000,
    S_OP   = 7'b0010000,
    S_ELAP = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // latched request and its in-bank flag
  in_t req;
  logic req_hit;

  // shared time base and per-timer status
  logic [31:0] tick_count;
  logic [31:0] tick_count_next;
  logic [1:0]  run_state [NUM_TIMERS];

  // working registers for the result under construction
  logic [IDX_W-1:0]     scan_idx;
  logic [MASK_BITS-1:0] mask;
  logic [31:0]          value;
  logic [31:0]          elapsed;
  logic [1:0]           nstate;
  logic [1:0]           nstate_next;
  row_t                 nrow;
  row_t                 nrow_next;

  out_t out_q;

  // row memory port
  logic [IDX_W-1:0] mem_addr;
  logic             mem_we;
  row_t             rd_row;

  // shared adder
  alu_req_t    alu_req;
  logic [31:0] alu_sum;
  logic        alu_carry;

  logic [IDX_W-1:0] cur_addr;
  logic [1:0]       cur_st;
  logic             live;
  logic             scan_last;
  logic             accept;
  logic             deliver;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign deliver   = (state == S_DONE) && (!out_valid || out_ready);
  assign cur_addr  = IDX_W'(req.timer_index);
  assign cur_st    = run_state[cur_addr];
  assign live      = (cur_st != TS_FINISHED);
  assign scan_last = (scan_idx == IDX_W'(NUM_TIMERS - 1));
  assign mem_we    = (state == S_ELAP);

  tsb_alu u_alu (
    .req   (alu_req),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  tsb_row_mem #(
    .DEPTH (NUM_TIMERS),
    .AW    (IDX_W)
  ) u_row_mem (
    .clk   (clk),
    .rst   (rst),
    .addr  (mem_addr),
    .we    (mem_we),
    .wdata (nrow),
    .rdata (rd_row)
  );

  // memory address: scan runs one row ahead of the compare
  always_comb begin
    case (state)
      S_TINC:  mem_addr = '0;
      S_SCAN:  mem_addr = IDX_W'(scan_idx + 1'b1);
      default: mem_addr = cur_addr;
    endcase
  end

  // adder operand selection per sequencer step
  always_comb begin
    alu_req = '0;
    case (state)
      S_TINC: begin
        alu_req = '{a: tick_count, b: 32'd1, sub: 1'b0};
      end
      S_SCAN: begin
        // carry set means now >= stop time
        alu_req = '{a: tick_count, b: rd_row.stop_time, sub: 1'b1};
      end
      S_OP: begin
        case (req.command)
          CMD_START:      alu_req = '{a: tick_count, b: req.duration_ms, sub: 1'b0};
          CMD_START_BASE: alu_req = '{a: req.base_time_ms, b: req.duration_ms, sub: 1'b0};
          CMD_RESUME:     alu_req = '{a: tick_count, b: rd_row.paused_remainder, sub: 1'b0};
          CMD_SUSPEND:    alu_req = '{a: rd_row.stop_time, b: tick_count, sub: 1'b1};
          CMD_QUERY:      alu_req = '{a: rd_row.stop_time, b: tick_count, sub: 1'b1};
          default:        alu_req = '0;
        endcase
      end
      S_ELAP: begin
        alu_req = '{a: tick_count, b: nrow.start_time, sub: 1'b1};
      end
      default: alu_req = '0;
    endcase
  end

  // wrap to zero instead of reaching all-ones
  assign tick_count_next = (alu_sum == TICK_WRAP) ? 32'd0 : alu_sum;

  // new row and status of the addressed timer, used in the operate step
  always_comb begin
    nrow_next   = rd_row;
    nstate_next = cur_st;
    case (req.command)
      CMD_START, CMD_START_BASE, CMD_RESUME: begin
        nstate_next          = TS_RUNNING;
        nrow_next.stop_time  = alu_sum;
        nrow_next.start_time = tick_count;
      end
      CMD_STOP: begin
        if (live) begin
          nstate_next = TS_FINISHED;
          nrow_next   = '0;
        end
      end
      CMD_SUSPEND: begin
        if (live) begin
          nstate_next                = TS_SUSPENDED;
          nrow_next.paused_remainder = alu_sum;
        end
      end
      CMD_RESET: begin
        nstate_next         = TS_FINISHED;
        nrow_next.stop_time = 32'd0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_item.command == CMD_TICK) begin
            state_next = S_TINC;
          end else if ({28'd0, in_item.timer_index} < 32'(NUM_TIMERS)) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_TINC: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_last) begin
          state_next = req_hit ? S_READ : S_DONE;
        end
      end
      S_READ: state_next = S_OP;
      S_OP:   state_next = S_ELAP;
      S_ELAP: state_next = S_DONE;
      S_DONE: begin
        if (deliver) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= 32'd0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        run_state[i] <= TS_FINISHED;
      end
    end else begin
      state <= state_next;
      if (state == S_TINC) begin
        tick_count <= tick_count_next;
      end
      if (state == S_SCAN && run_state[scan_idx] == TS_RUNNING && alu_carry) begin
        run_state[scan_idx] <= TS_FINISHED;
      end
      if (state == S_ELAP) begin
        run_state[cur_addr] <= nstate;
      end
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req     <= in_item;
          req_hit <= ({28'd0, in_item.timer_index} < 32'(NUM_TIMERS));
          value   <= 32'd0;
          elapsed <= 32'd0;
          nstate  <= TS_FINISHED;
          mask    <= '0;
        end
      end
      S_TINC: begin
        scan_idx <= '0;
      end
      S_SCAN: begin
        // timers past the mask width expire but get no bit
        if (run_state[scan_idx] == TS_RUNNING && alu_carry &&
            (32'(scan_idx) < 32'(MASK_BITS))) begin
          mask[4'(scan_idx)] <= 1'b1;
        end
        scan_idx <= IDX_W'(scan_idx + 1'b1);
      end
      S_OP: begin
        nrow   <= nrow_next;
        nstate <= nstate_next;
        // remaining form of suspend and query both report stop minus now
        if (live && ((req.command == CMD_SUSPEND && req.want_remaining) ||
                     req.command == CMD_QUERY)) begin
          value <= alu_sum;
        end
      end
      S_ELAP: begin
        elapsed <= alu_sum;
        // elapsed form of suspend equals now minus the kept start time
        if (req.command == CMD_SUSPEND && nstate == TS_SUSPENDED && !req.want_remaining) begin
          value <= alu_sum;
        end
      end
      S_DONE: begin
        if (deliver) begin
          out_q <= '{result_ms:    value,
                     elapsed_ms:   elapsed,
                     timer_state:  nstate,
                     expired_mask: mask,
                     now_ms:       tick_count};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_item = out_q;

  // sequencer sanity
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_count_wraps: assert property (@(posedge clk) disable iff (rst) tick_count != TICK_WRAP)
    else $error("tick count reached all-ones");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted request did not start the sequencer");

  a_deliver_sets_valid: assert property (@(posedge clk) disable iff (rst)
    deliver |=> out_valid && state == S_IDLE)
    else $error("result not presented after delivery");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_last) |=> (state == S_READ || state == S_DONE))
    else $error("scan did not end after the last timer");

endmodule
